// ----- rtl/lte_pkg.sv -----
`default_nettype none
package lte_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned LW    = IW + 1;          // link / list head width, holds "none"
  localparam logic [LW-1:0] NONE_IX = LW'(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);

  // entry word in the lease RAM: {owner, expiry}
  localparam int unsigned EW = 8 + 64;

  localparam logic [2:0] OP_ACQUIRE  = 3'd0;
  localparam logic [2:0] OP_CLOSE    = 3'd1;
  localparam logic [2:0] OP_COMP_STOP = 3'd2;
  localparam logic [2:0] OP_REV_EXP  = 3'd3;
  localparam logic [2:0] OP_REV_ALL  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_DENIED    = 3'd2;
  localparam logic [2:0] ST_RES_LIMIT = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] REG_ALLOWED  = 2'd0;
  localparam logic [1:0] REG_MAX_PC   = 2'd1;
  localparam logic [1:0] REG_DEF_DUR  = 2'd2;
  localparam logic [1:0] REG_MAX_DUR  = 2'd3;

  localparam logic [5:0]  RST_ALLOWED = 6'd63;
  localparam logic [4:0]  RST_MAX_PC  = 5'd2;
  localparam logic [31:0] RST_DEF_DUR = 32'd30000;
  localparam logic [31:0] RST_MAX_DUR = 32'd600000;

  typedef struct packed {
    logic       any_active;
    logic [4:0] released_count;
    logic [3:0] out_reason;
    logic [7:0] out_component;
    logic [3:0] out_slot;
    logic [2:0] status;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/lte_ram.sv -----
`default_nettype none
module lte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lease_table_with_expiry_top.sv -----
// Lease table with expiry: 16 slots, owner/expiry in a synchronous RAM.
// One transaction is worked on at a time, throughput set by the list walk (for
// acquire and revoke, a RAM read then a compare per active entry). Output
// stalls hold the block until the sink takes the result.
// Reset (rst_ni low, async): lists rebuilt (all slots free), registers to defaults.
`default_nettype none
module lease_table_with_expiry_top
  import lte_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  // slave side; tdata: component[7:0], kind[10:8], dur_given[11],
  // duration[43:12], slot[47:44], now[111:48], reason[115:112], zero pad
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [119:0] s_axis_tdata_i,
  input  wire  [2:0]   s_axis_tuser_i,   // op[2:0]
  // master side; tdata: status[2:0], out_slot[6:3], out_component[14:7],
  // out_reason[18:15], released_count[23:19], any_active[24], zero pad
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,   // last
  // configuration
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_ONE, S_A_RD, S_A_CMP, S_A_FIN, S_C_WALK,
    S_R_RD, S_R_CMP, S_R_SUM
  } state_e;

  state_e state_q;

  // config registers
  logic [5:0]  allowed_q;
  logic [4:0]  max_pc_q;
  logic [31:0] def_dur_q, max_dur_q;

  // list state kept in flops (small, one entry looked up per cycle)
  logic [LW-1:0] link_q [SLOTS];
  logic [SLOTS-1:0] in_use_q;
  logic [LW-1:0] free_first_q, active_first_q;

  // transaction context
  logic [2:0]  op_q;
  logic [7:0]  comp_q;
  logic [31:0] dur_q;
  logic [63:0] now_q;
  logic [3:0]  rsn_q;
  logic [IW-1:0] slot_q;
  logic [2:0]  st_q;
  logic [LW-1:0] ix_q, prev_q;
  logic [CW-1:0] cnt_q;

  // output register
  logic ovalid_q;
  res_t res_q;
  logic olast_q;

  // input unpack
  logic [7:0]  in_comp;
  logic [2:0]  in_kind;
  logic        in_hasd;
  logic [31:0] in_dur;
  logic [3:0]  in_slot;
  logic [63:0] in_now;
  logic [3:0]  in_rsn;
  assign in_comp = s_axis_tdata_i[7:0];
  assign in_kind = s_axis_tdata_i[10:8];
  assign in_hasd = s_axis_tdata_i[11];
  assign in_dur  = s_axis_tdata_i[43:12];
  assign in_slot = s_axis_tdata_i[47:44];
  assign in_now  = s_axis_tdata_i[111:48];
  assign in_rsn  = s_axis_tdata_i[115:112];

  // RAM
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [7:0]    rd_owner;
  logic [63:0]   rd_expiry;
  assign rd_owner  = ram_rdata[EW-1 -: 8];
  assign rd_expiry = ram_rdata[63:0];

  lte_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_acc, out_free;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;

  // precheck for acquire on the incoming transaction
  logic [31:0] in_d;
  logic [2:0]  acq_st;
  always_comb begin
    in_d   = in_hasd ? in_dur : def_dur_q;
    acq_st = ST_OK;
    if (in_kind == 3'd0 || in_kind == 3'd7) begin
      acq_st = ST_INVALID;
    end else if (!allowed_q[in_kind - 3'd1] || in_d == 32'd0 || in_d > max_dur_q) begin
      acq_st = ST_DENIED;
    end
  end

  logic [64:0] exp_sum;
  assign exp_sum = {1'b0, now_q} + {33'd0, dur_q};

  logic hit;
  always_comb begin
    case (op_q)
      OP_COMP_STOP: hit = (rd_owner == comp_q);
      OP_REV_EXP:   hit = (now_q >= rd_expiry);
      default:      hit = 1'b1;
    endcase
  end

  // a result transaction is loaded into the output register this cycle
  logic out_load;
  always_comb begin
    unique case (state_q)
      S_ONE, S_A_FIN, S_R_SUM: out_load = out_free;
      S_C_WALK: out_load = out_free && ix_q[IW-1:0] == slot_q && ix_q != NONE_IX;
      S_R_CMP:  out_load = out_free && hit && op_q != OP_COMP_STOP;
      default:  out_load = 1'b0;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ix_q[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = free_first_q[IW-1:0];
    ram_wdata = {comp_q, exp_sum[63:0]};
    if (state_q == S_IDLE) begin
      ram_re    = in_acc;
      ram_raddr = in_slot;
    end else if ((state_q == S_A_RD || state_q == S_R_RD) && ix_q != NONE_IX) begin
      ram_re = 1'b1;
    end
    if (state_q == S_A_FIN && out_free && cnt_q < CW'(max_pc_q) && !exp_sum[64]
        && free_first_q != NONE_IX) begin
      ram_we = 1'b1;
    end
  end

  // APB
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      REG_ALLOWED: prdata = {26'd0, allowed_q};
      REG_MAX_PC:  prdata = {27'd0, max_pc_q};
      REG_DEF_DUR: prdata = def_dur_q;
      REG_MAX_DUR: prdata = max_dur_q;
      default:     prdata = 32'd0;
    endcase
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {7'd0, res_q};
  assign m_axis_tlast_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q <= RST_ALLOWED;
      max_pc_q  <= RST_MAX_PC;
      def_dur_q <= RST_DEF_DUR;
      max_dur_q <= RST_MAX_DUR;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ALLOWED: allowed_q <= pwdata[5:0];
        REG_MAX_PC:  max_pc_q  <= pwdata[4:0];
        REG_DEF_DUR: def_dur_q <= pwdata;
        REG_MAX_DUR: max_dur_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser_i;
      comp_q <= in_comp;
      dur_q  <= in_d;
      now_q  <= in_now;
      rsn_q  <= in_rsn;
      slot_q <= in_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      for (int i = 0; i < SLOTS; i++) begin
        link_q[i] <= LW'(i + 1);
      end
      in_use_q       <= '0;
      free_first_q   <= '0;
      active_first_q <= NONE_IX;
      ovalid_q       <= 1'b0;
      olast_q        <= 1'b0;
      res_q          <= '0;
      st_q           <= ST_OK;
      ix_q           <= NONE_IX;
      prev_q         <= NONE_IX;
      cnt_q          <= '0;
    end else begin
      // load a new result, else drop the one taken by the sink
      ovalid_q <= out_load || (ovalid_q && !m_axis_tready_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ix_q   <= active_first_q;
            prev_q <= NONE_IX;
            cnt_q  <= '0;
            unique case (s_axis_tuser_i)
              OP_ACQUIRE: begin
                st_q    <= acq_st;
                state_q <= (acq_st == ST_OK) ? S_A_RD : S_ONE;
              end
              OP_CLOSE: begin
                st_q    <= ST_NOT_FOUND;
                state_q <= in_use_q[in_slot] ? S_C_WALK : S_ONE;
              end
              OP_COMP_STOP, OP_REV_EXP, OP_REV_ALL: state_q <= S_R_RD;
              default: begin
                st_q    <= ST_INVALID;
                state_q <= S_ONE;
              end
            endcase
          end
        end
        S_ONE: begin
          if (out_free) begin
            olast_q  <= 1'b1;
            res_q    <= '{any_active: active_first_q != NONE_IX,
                          status: st_q, default: '0};
            state_q  <= S_IDLE;
          end
        end
        // count leases held by the requester
        S_A_RD: state_q <= (ix_q == NONE_IX) ? S_A_FIN : S_A_CMP;
        S_A_CMP: begin
          if (rd_owner == comp_q) begin
            cnt_q <= cnt_q + CW'(1);
          end
          ix_q    <= link_q[ix_q[IW-1:0]];
          state_q <= S_A_RD;
        end
        S_A_FIN: begin
          if (out_free) begin
            olast_q  <= 1'b1;
            state_q  <= S_IDLE;
            if (ram_we) begin
              free_first_q                   <= link_q[free_first_q[IW-1:0]];
              link_q[free_first_q[IW-1:0]]   <= active_first_q;
              active_first_q                 <= free_first_q;
              in_use_q[free_first_q[IW-1:0]] <= 1'b1;
              res_q <= '{status: ST_OK, out_slot: free_first_q[IW-1:0],
                         out_component: comp_q, any_active: 1'b1, default: '0};
            end else begin
              res_q <= '{status: ST_RES_LIMIT,
                         any_active: active_first_q != NONE_IX, default: '0};
            end
          end
        end
        // find predecessor of the closed slot; owner is in RAM read data
        S_C_WALK: begin
          if (ix_q[IW-1:0] == slot_q && ix_q != NONE_IX) begin
            if (out_free) begin
              if (prev_q == NONE_IX) begin
                active_first_q <= link_q[slot_q];
              end else begin
                link_q[prev_q[IW-1:0]] <= link_q[slot_q];
              end
              in_use_q[slot_q] <= 1'b0;
              link_q[slot_q]   <= free_first_q;
              free_first_q     <= {1'b0, slot_q};
              olast_q  <= 1'b1;
              res_q <= '{status: ST_OK, out_slot: slot_q, out_component: rd_owner,
                         released_count: 5'd1,
                         any_active: (prev_q == NONE_IX) ? (link_q[slot_q] != NONE_IX)
                                                         : 1'b1,
                         default: '0};
              state_q <= S_IDLE;
            end
          end else begin
            prev_q <= ix_q;
            ix_q   <= link_q[ix_q[IW-1:0]];
          end
        end
        S_R_RD: state_q <= (ix_q == NONE_IX) ? S_R_SUM : S_R_CMP;
        S_R_CMP: begin
          if (!hit) begin
            prev_q  <= ix_q;
            ix_q    <= link_q[ix_q[IW-1:0]];
            state_q <= S_R_RD;
          end else if (op_q == OP_COMP_STOP || out_free) begin
            if (prev_q == NONE_IX) begin
              active_first_q <= link_q[ix_q[IW-1:0]];
            end else begin
              link_q[prev_q[IW-1:0]] <= link_q[ix_q[IW-1:0]];
            end
            in_use_q[ix_q[IW-1:0]] <= 1'b0;
            link_q[ix_q[IW-1:0]]   <= free_first_q;
            free_first_q           <= ix_q;
            ix_q                   <= link_q[ix_q[IW-1:0]];
            cnt_q                  <= cnt_q + CW'(1);
            if (op_q != OP_COMP_STOP) begin
              olast_q  <= 1'b0;
              res_q <= '{status: ST_OK, out_slot: ix_q[IW-1:0],
                         out_component: rd_owner, out_reason: rsn_q, default: '0};
            end
            state_q <= S_R_RD;
          end
        end
        S_R_SUM: begin
          if (out_free) begin
            olast_q  <= 1'b1;
            res_q <= '{status: ST_OK,
                       out_reason: (op_q == OP_COMP_STOP) ? 4'd0 : rsn_q,
                       released_count: 5'(cnt_q),
                       any_active: active_first_q != NONE_IX, default: '0};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // every slot is on exactly one list, so both heads can never be empty together
  a_lists_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(free_first_q == NONE_IX && active_first_q == NONE_IX))
    else $error("both list heads empty");

  // active list empty exactly when no slot is in use
  a_active_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_first_q == NONE_IX) == ($countones(in_use_q) == 0))
    else $error("active head disagrees with in-use bits");

  // a transaction is only taken while no list walk is running, and it then starts
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted transaction not started");

  // lease count (held or freed) never exceeds the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("count out of range");

endmodule
`default_nettype wire
